/* rtl/core/cfrx_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cfrx_pkg;

   localparam int PAYLOAD_BYTES = 20;
   localparam int ADDR_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
   localparam int POS_W = 6;

   localparam logic [7:0] START_BYTE = 8'h2F;
   localparam logic [7:0] TAIL_BYTE = 8'h0A;
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_TOP = 16'h8000;

   localparam logic [1:0] ST_GOOD = 2'd0;
   localparam logic [1:0] ST_BAD_TAIL = 2'd1;
   localparam logic [1:0] ST_CRC_BAD = 2'd2;

   typedef struct packed {
      logic en;
      logic [ADDR_W-1:0] addr;
      logic [7:0] data;
   } wr_port_type;

   typedef struct packed {
      logic valid;
      logic [1:0] status;
   } frame_end_type;

endpackage

`default_nettype wire

/* rtl/core/cfrx_ifc.sv */
`timescale 1ns / 1ps
`default_nettype none

interface cfrx_req_if;
   logic valid;
   logic ready;
   logic [7:0] rx_byte;
   logic timeout;
   modport source(output valid, rx_byte, timeout, input ready);
   modport sink(input valid, rx_byte, timeout, output ready);
endinterface

interface cfrx_rsp_if;
   logic valid;
   logic ready;
   logic [1:0] status;
   logic [5:0] byte_index;
   logic [7:0] payload_byte;
   logic last;
   modport source(output valid, status, byte_index, payload_byte, last, input ready);
   modport sink(input valid, status, byte_index, payload_byte, last, output ready);
endinterface

`default_nettype wire

/* rtl/core/cfrx_payload_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module cfrx_payload_ram (
   input wire logic clock,
   input wire cfrx_pkg::wr_port_type wr,
   input wire logic rd_en,
   input wire logic [cfrx_pkg::ADDR_W-1:0] rd_addr,
   output logic [7:0] rd_data
);

   logic [7:0] mem [cfrx_pkg::PAYLOAD_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/core/cfrx_frame_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module cfrx_frame_ctrl (
   input wire logic clock,
   input wire logic reset,
   input wire logic accept,
   input wire logic [7:0] rx_byte,
   input wire logic timeout,
   output cfrx_pkg::wr_port_type wr,
   output cfrx_pkg::frame_end_type frame_end
);

   localparam logic [cfrx_pkg::POS_W-1:0] POS_CRC_HI =
      cfrx_pkg::POS_W'(cfrx_pkg::PAYLOAD_BYTES);
   localparam logic [cfrx_pkg::POS_W-1:0] POS_CRC_LO =
      cfrx_pkg::POS_W'(cfrx_pkg::PAYLOAD_BYTES + 1);

   logic in_frame_ff, in_frame_in;
   logic [cfrx_pkg::POS_W-1:0] position_ff, position_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0] crc_hi_ff, crc_hi_in;
   logic [7:0] crc_lo_ff, crc_lo_in;
   logic [15:0] crc_next;

   function automatic logic [15:0] crc_add_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if ((c & cfrx_pkg::CRC_TOP) != 16'h0000) begin
            c = (c << 1) ^ cfrx_pkg::CRC_POLY;
         end else begin
            c = c << 1;
         end
      end
      return c;
   endfunction

   assign crc_next = crc_add_byte(in_frame_ff ? crc_ff : 16'h0000, rx_byte);

   always_comb begin
      in_frame_in = in_frame_ff;
      position_in = position_ff;
      crc_in = crc_ff;
      crc_hi_in = crc_hi_ff;
      crc_lo_in = crc_lo_ff;
      wr.en = 1'b0;
      wr.addr = position_ff[cfrx_pkg::ADDR_W-1:0];
      wr.data = rx_byte;
      frame_end.valid = 1'b0;
      frame_end.status = cfrx_pkg::ST_GOOD;
      if (accept) begin
         priority if (timeout) begin
            in_frame_in = 1'b0;
            position_in = '0;
         end else if (!in_frame_ff) begin
            if (rx_byte == cfrx_pkg::START_BYTE) begin
               in_frame_in = 1'b1;
               position_in = '0;
               crc_in = crc_next;
            end
         end else if (position_ff < POS_CRC_HI) begin
            wr.en = 1'b1;
            crc_in = crc_next;
            position_in = position_ff + 1'b1;
         end else if (position_ff == POS_CRC_HI) begin
            crc_hi_in = rx_byte;
            position_in = position_ff + 1'b1;
         end else if (position_ff == POS_CRC_LO) begin
            crc_lo_in = rx_byte;
            position_in = position_ff + 1'b1;
         end else begin
            frame_end.valid = 1'b1;
            priority if (rx_byte != cfrx_pkg::TAIL_BYTE) begin
               frame_end.status = cfrx_pkg::ST_BAD_TAIL;
            end else if ({crc_hi_ff, crc_lo_ff} != crc_ff) begin
               frame_end.status = cfrx_pkg::ST_CRC_BAD;
            end else begin
               frame_end.status = cfrx_pkg::ST_GOOD;
            end
            in_frame_in = 1'b0;
            position_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         position_ff <= '0;
         crc_ff <= '0;
         crc_hi_ff <= '0;
         crc_lo_ff <= '0;
      end else begin
         in_frame_ff <= in_frame_in;
         position_ff <= position_in;
         crc_ff <= crc_in;
         crc_hi_ff <= crc_hi_in;
         crc_lo_ff <= crc_lo_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/crc16_checked_frame_receiver_unit.sv */
// crc16 checked frame receiver
// req channel: one serial byte (rx_byte) or a timeout flag per transfer.
// the block hunts for start byte 0x2f, stores the payload bytes in a small
// synchronous buffer, checks the tail byte and the crc-16 (poly 0x1021, init 0)
// and answers on the rsp channel.
// rsp channel: a good frame gives one transfer per payload byte, byte_index
// counting up, last set on the final one; a bad frame gives one transfer with
// status 1 (bad tail) or 2 (crc mismatch) and last set.
// throughput: while no frame is being released, one req transfer per cycle.
// after the tail of a good frame req ready stays low while the payload is read
// back, each byte going through a buffer read (S_READ), then an output load
// (S_LOAD). after the tail transfer a good frame passes S_READ and S_LOAD
// before its first payload result is registered, a bad frame passes S_ERR
// before its error result is registered.
// the rsp side has an output register, so once the readout is done a req
// transfer is taken while the last result waits; a stalled receiver holds the
// current result and the readout pauses until it is taken.
// reset (synchronous) returns to hunting and empties the output register;
// the buffer is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module crc16_checked_frame_receiver_unit (
   input wire logic clock,
   input wire logic reset,
   cfrx_req_if.sink req_chan,
   cfrx_rsp_if.source rsp_chan
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_LOAD = 2'd2;
   localparam logic [1:0] S_ERR = 2'd3;

   localparam logic [cfrx_pkg::ADDR_W-1:0] LAST_IDX =
      cfrx_pkg::ADDR_W'(cfrx_pkg::PAYLOAD_BYTES - 1);

   logic [1:0] state_ff, state_in;
   logic [cfrx_pkg::ADDR_W-1:0] idx_ff, idx_in;
   logic [1:0] err_status_ff, err_status_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic [5:0] rsp_index_ff, rsp_index_in;
   logic [7:0] rsp_data_ff, rsp_data_in;
   logic rsp_last_ff, rsp_last_in;

   logic accept;
   logic out_free;
   logic rd_en;
   logic [7:0] rd_data;
   cfrx_pkg::wr_port_type wr;
   cfrx_pkg::frame_end_type frame_end;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign rd_en = (state_ff == S_READ);

   cfrx_frame_ctrl u_frame_ctrl (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .rx_byte(req_chan.rx_byte),
      .timeout(req_chan.timeout),
      .wr(wr),
      .frame_end(frame_end)
   );

   cfrx_payload_ram u_payload_ram (
      .clock(clock),
      .wr(wr),
      .rd_en(rd_en),
      .rd_addr(idx_ff),
      .rd_data(rd_data)
   );

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      err_status_in = err_status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in = rsp_index_ff;
      rsp_data_in = rsp_data_ff;
      rsp_last_in = rsp_last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (frame_end.valid) begin
               idx_in = '0;
               err_status_in = frame_end.status;
               state_in = (frame_end.status == cfrx_pkg::ST_GOOD) ? S_READ : S_ERR;
            end
         end
         S_READ: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = cfrx_pkg::ST_GOOD;
               rsp_index_in = 6'(idx_ff);
               rsp_data_in = rd_data;
               rsp_last_in = (idx_ff == LAST_IDX);
               if (idx_ff == LAST_IDX) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  state_in = S_READ;
               end
            end
         end
         S_ERR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = err_status_ff;
               rsp_index_in = '0;
               rsp_data_in = '0;
               rsp_last_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      err_status_ff <= err_status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff <= rsp_index_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.status = rsp_status_ff;
   assign rsp_chan.byte_index = rsp_index_ff;
   assign rsp_chan.payload_byte = rsp_data_ff;
   assign rsp_chan.last = rsp_last_ff;

   // good frame end starts the buffer readout
   a_good_starts_read: assert property (@(posedge clock) disable iff (reset)
      frame_end.valid && frame_end.status == cfrx_pkg::ST_GOOD |=> state_ff == S_READ)
      else $error("good frame did not start readout");

   // last payload transfer carries the final index
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff && rsp_status_ff == cfrx_pkg::ST_GOOD
      |-> rsp_index_ff == 6'(cfrx_pkg::PAYLOAD_BYTES - 1))
      else $error("last payload transfer has wrong index");

   // error transfers are single, zero filled
   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != cfrx_pkg::ST_GOOD
      |-> rsp_last_ff && rsp_index_ff == '0 && rsp_data_ff == '0)
      else $error("malformed error transfer");

   // no buffer write during readout
   a_no_write_in_readout: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !wr.en)
      else $error("buffer written during readout");

endmodule

`default_nettype wire
